// ===== design/assert_macros.svh =====
// assert_macros.svh: assertion macros shared by the address validator RTL.
// Depends on a clk and an active-low rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define DAV_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("address validator assertion failed");

// Check that a condition implies a consequent in the same cycle.
`define DAV_ASSERT_IMP(label, cond, cons) \
    `DAV_ASSERT(label, (cond) |-> (cons))

// Check that a condition implies a consequent in the next cycle.
`define DAV_ASSERT_NEXT(label, cond, cons) \
    `DAV_ASSERT(label, (cond) |=> (cons))

`endif

// ===== design/dav_pkg.sv =====
// dav_pkg: types, codes and constants of the address validator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dav_pkg;

    // Default number of rows in one address
    localparam int DAV_NODES = 9;

    localparam logic [31:0] CHOSEN_BITS = 32'h8080_8080;
    localparam logic [7:0]  EMPTY_BYTE  = 8'h7f;
    localparam logic [31:0] EMPTY_ALL   = 32'h7f7f_7f7f;
    localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;

    // Result codes, in order of check priority
    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_NAT_MISPLACED   = 3'd1,
        ST_CHOSEN          = 3'd2,
        ST_EMPTY_MISPLACED = 3'd3,
        ST_RANGE           = 3'd4,
        ST_NOT_TOPO        = 3'd5,
        ST_NO_ENTRY        = 3'd6,
        ST_MULTI_COMP      = 3'd7
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_COLLECT,
        S_SCAN,
        S_LANES,
        S_MERGE
    } dav_state_t;

    // What one lane found in its row
    typedef struct packed {
        status_t code;
        logic    all_empty;
    } lane_res_t;

endpackage

// ===== design/dav_lane.sv =====
// dav_lane: checks the edge byte list of one stored row.
// Depends on dav_pkg; one instance per row in the top level.
`timescale 1ns / 1ps

module dav_lane #(
    parameter int NODES = dav_pkg::DAV_NODES,
    parameter int IDX   = 0,
    parameter int N_W   = $clog2(NODES + 1),
    parameter int IW    = (NODES > 1) ? $clog2(NODES) : 1
) (
    input  logic [31:0]         edges,
    input  logic [N_W-1:0]      node_n,
    output dav_pkg::lane_res_t  res,
    output logic [NODES-1:0]    vis
);
    import dav_pkg::*;

    logic        active;
    logic        not_last;

    assign active   = 32'(node_n) > 32'(IDX);
    assign not_last = 32'(node_n) > 32'(IDX + 1);

    // Reject a set chosen bit, else walk the edge bytes of the word from the top, stop at the first empty one or error
    always_comb
    begin
        logic        done;
        logic [7:0]  e;
        logic [31:0] tail;
        done          = 1'b0;
        e             = '0;
        tail          = '0;
        res.code      = ST_OK;
        res.all_empty = (edges == EMPTY_ALL);
        vis           = '0;
        if (active)
        begin
            if ((edges & CHOSEN_BITS) != '0)
            begin
                res.code = ST_CHOSEN;
            end
            else
            begin
                for (int j = 0; j < 4; j++)
                begin
                    e    = edges[31 - 8 * j -: 8];
                    tail = ALL_ONES >> (8 * j);
                    if (!done)
                    begin
                        if (e == EMPTY_BYTE)
                        begin
                            if ((edges & tail) != (EMPTY_ALL & tail))
                                res.code = ST_EMPTY_MISPLACED;
                            done = 1'b1;
                        end
                        else if (32'(e) >= 32'(node_n))
                        begin
                            res.code = ST_RANGE;
                            done     = 1'b1;
                        end
                        else if (not_last && (32'(e) <= 32'(IDX)))
                        begin
                            res.code = ST_NOT_TOPO;
                            done     = 1'b1;
                        end
                        else
                        begin
                            vis[e[IW-1:0]] = 1'b1;
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== design/dav_merge.sv =====
// dav_merge: combines the lane findings into one status and node count.
// Depends on dav_pkg; fed by the registered lane results of the top level.
`timescale 1ns / 1ps

module dav_merge #(
    parameter int NODES = dav_pkg::DAV_NODES,
    parameter int N_W   = $clog2(NODES + 1)
) (
    input  dav_pkg::lane_res_t  lane_res [NODES],
    input  logic [NODES-1:0]    lane_vis [NODES],
    input  logic [N_W-1:0]      node_n,
    input  logic                nat_bad,
    output dav_pkg::status_t    status,
    output logic [3:0]          node_count
);
    import dav_pkg::*;

    logic [NODES-1:0] vis_all;
    logic [NODES-1:0] vis_want;
    logic             lane_err;
    status_t          lane_code;
    logic             last_empty;

    // Fold the visited masks and build the mask of all node rows
    always_comb
    begin
        vis_all = '0;
        for (int i = 0; i < NODES; i++)
        begin
            vis_all     = vis_all | lane_vis[i];
            vis_want[i] = 32'(node_n) > 32'(i);
        end
    end

    // Take the first lane that failed, and the entry flag of the last node row
    always_comb
    begin
        lane_err   = 1'b0;
        lane_code  = ST_OK;
        last_empty = 1'b0;
        for (int i = 0; i < NODES; i++)
        begin
            if (!lane_err && lane_res[i].code != ST_OK)
            begin
                lane_err  = 1'b1;
                lane_code = lane_res[i].code;
            end
            if (32'(node_n) == 32'(i + 1))
                last_empty = lane_res[i].all_empty;
        end
    end

    // Apply the checks in priority order
    always_comb
    begin
        if (nat_bad)
            status = ST_NAT_MISPLACED;
        else if (lane_err)
            status = lane_code;
        else if (node_n != '0 && last_empty)
            status = ST_NO_ENTRY;
        else if (node_n != '0 && vis_all != vis_want)
            status = ST_MULTI_COMP;
        else
            status = ST_OK;
        node_count = (status == ST_OK) ? 4'(node_n) : 4'd0;
    end

endmodule

// ===== design/dav_address_validator_top.sv =====
// dag_address_validator_core: row store, lane array and merge of the validator.
// Depends on dav_pkg, dav_lane, dav_merge and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Rows of one address come in on start/row_type/edge_word, one per cycle while
// busy is low. The row that completes a group of NODES rows starts the check:
// busy then stays high through the states S_SCAN (find the first NAT row),
// S_LANES (run one check lane per row) and S_MERGE (merge the lane findings),
// and the result shows on status and node_count with done high for exactly
// one cycle right after, while the first row of the next address may already
// be accepted. The receiver cannot stall: sample done every cycle.
// nat_type is written through cfg_valid/cfg_data (cfg_ready is always high)
// and is compared with each row as it arrives.
module dag_address_validator_core #(
    parameter int NODES = dav_pkg::DAV_NODES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] row_type,
    input  logic [31:0] edge_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic [3:0]  node_count
);
    import dav_pkg::*;

    localparam int N_W   = $clog2(NODES + 1);
    localparam int CNT_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(NODES - 1);

    dav_state_t       state_reg, state_next;
    logic [CNT_W-1:0] row_cnt_reg;
    logic [31:0]      nat_type_reg;
    logic [31:0]      edges_reg [NODES];
    logic             is_nat_reg [NODES];
    logic [N_W-1:0]   node_n_reg, node_n_next;
    logic             nat_bad_reg, nat_bad_next;
    lane_res_t        lane_res_reg [NODES];
    lane_res_t        lane_res_next [NODES];
    logic [NODES-1:0] lane_vis_reg [NODES];
    logic [NODES-1:0] lane_vis_next [NODES];
    status_t          merge_status;
    logic [3:0]       merge_count;
    logic             done_reg;
    logic [2:0]       status_reg;
    logic [3:0]       node_count_reg;
    logic             row_take;

    assign busy       = (state_reg != S_COLLECT);
    assign row_take   = start && !busy;
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign status     = status_reg;
    assign node_count = node_count_reg;

    // Hold the NAT type register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nat_type_reg <= '0;
        else if (cfg_valid && cfg_ready)
            nat_type_reg <= cfg_data;
    end

    // Store each accepted row at the row counter
    always_ff @(posedge clk)
    begin
        if (row_take)
        begin
            edges_reg[row_cnt_reg]  <= edge_word;
            is_nat_reg[row_cnt_reg] <= (row_type == nat_type_reg);
        end
    end

    // Advance the row counter, wrap after the last row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_cnt_reg <= '0;
        else if (row_take)
            row_cnt_reg <= (row_cnt_reg == LAST_ROW) ? '0 : row_cnt_reg + 1'b1;
    end

    // Controller state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_COLLECT;
        else
            state_reg <= state_next;
    end

    // Controller next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_COLLECT:
                if (row_take && row_cnt_reg == LAST_ROW)
                    state_next = S_SCAN;
            S_SCAN:  state_next = S_LANES;
            S_LANES: state_next = S_MERGE;
            S_MERGE: state_next = S_COLLECT;
            default: state_next = S_COLLECT;
        endcase
    end

    // Find the first NAT row and flag a node row after it
    always_comb
    begin
        logic seen;
        seen         = 1'b0;
        nat_bad_next = 1'b0;
        node_n_next  = N_W'(NODES);
        for (int i = 0; i < NODES; i++)
        begin
            if (seen)
            begin
                if (!is_nat_reg[i])
                    nat_bad_next = 1'b1;
            end
            else if (is_nat_reg[i])
            begin
                node_n_next = N_W'(i);
                seen        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN)
        begin
            node_n_reg  <= node_n_next;
            nat_bad_reg <= nat_bad_next;
        end
    end

    // One check lane per stored row
    for (genvar g = 0; g < NODES; g++)
    begin : g_lane
        dav_lane #(
            .NODES (NODES),
            .IDX   (g),
            .N_W   (N_W)
        ) u_lane (
            .edges  (edges_reg[g]),
            .node_n (node_n_reg),
            .res    (lane_res_next[g]),
            .vis    (lane_vis_next[g])
        );
    end

    // Register the lane findings
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LANES)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                lane_res_reg[i] <= lane_res_next[i];
                lane_vis_reg[i] <= lane_vis_next[i];
            end
        end
    end

    dav_merge #(
        .NODES (NODES),
        .N_W   (N_W)
    ) u_merge (
        .lane_res   (lane_res_reg),
        .lane_vis   (lane_vis_reg),
        .node_n     (node_n_reg),
        .nat_bad    (nat_bad_reg),
        .status     (merge_status),
        .node_count (merge_count)
    );

    // Drive the result strobe for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (state_reg == S_MERGE);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MERGE)
        begin
            status_reg     <= merge_status;
            node_count_reg <= merge_count;
        end
    end

    // A result follows the merge cycle and nothing else
    `DAV_ASSERT_IMP(a_done_after_merge, done, $past(state_reg == S_MERGE))
    // The last row of an address starts the check
    `DAV_ASSERT_NEXT(a_last_row_scans, row_take && row_cnt_reg == LAST_ROW,
        state_reg == S_SCAN && row_cnt_reg == '0)
    // A failed check reports no nodes
    `DAV_ASSERT_IMP(a_fail_no_count, done && status != ST_OK, node_count == 4'd0)
    // No row is taken during the check
    `DAV_ASSERT_IMP(a_hold_counter, busy, $stable(row_cnt_reg) || $past(!busy))

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for dag_address_validator_core.
// Depends on dav_pkg and the validator RTL; the expected verdicts come from
// the address_verdicts class below, and plain tasks drive rows and writes.
`timescale 1ns / 1ps

module tb;
    import dav_pkg::*;

    localparam int NODES         = DAV_NODES;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ADDRS_PER_RUN = 6;

    typedef struct {
        status_t    status;
        logic [3:0] node_count;
    } verdict_t;

    // Predict one verdict per completed address and match it against done
    class address_verdicts;
        logic [31:0] nat_type;
        logic [31:0] row_edges [NODES];
        bit          row_is_nat [NODES];
        int          row_counter;
        verdict_t    awaited [$];
        int          errors;

        function new();
            nat_type    = '0;
            row_counter = 0;
            errors      = 0;
            foreach (row_edges[i])
            begin
                row_edges[i]  = '0;
                row_is_nat[i] = 1'b0;
            end
        endfunction

        function void set_nat(input logic [31:0] value);
            nat_type = value;
        endfunction

        // Check the stored address in the same order as the hardware priorities
        function status_t judge(output logic [3:0] count);
            int          n;
            int          i;
            int          j;
            int          e;
            bit          saw_nat;
            bit          row_done;
            logic [31:0] w;
            logic [31:0] keep;
            logic [31:0] visited;
            count   = '0;
            n       = NODES;
            saw_nat = 1'b0;
            visited = '0;
            for (i = 0; i < NODES; i++)
            begin
                if (saw_nat)
                begin
                    if (!row_is_nat[i])
                        return ST_NAT_MISPLACED;
                end
                else if (row_is_nat[i])
                begin
                    n       = i;
                    saw_nat = 1'b1;
                end
            end
            for (i = 0; i < n; i++)
            begin
                w        = row_edges[i];
                keep     = ALL_ONES;
                row_done = 1'b0;
                if ((w & CHOSEN_BITS) != '0)
                    return ST_CHOSEN;
                for (j = 0; j < 4 && !row_done; j++)
                begin
                    e = int'(w[31 - 8 * j -: 8]);
                    if (e == int'(EMPTY_BYTE))
                    begin
                        // Once empty, the rest of the row must stay empty
                        if ((w & keep) != (EMPTY_ALL & keep))
                            return ST_EMPTY_MISPLACED;
                        row_done = 1'b1;
                    end
                    else
                    begin
                        if (e >= n)
                            return ST_RANGE;
                        if (i + 1 < n && e <= i)
                            return ST_NOT_TOPO;
                        keep       = keep >> 8;
                        visited[e] = 1'b1;
                    end
                end
            end
            if (n >= 1)
            begin
                if (row_edges[n - 1] == EMPTY_ALL)
                    return ST_NO_ENTRY;
                if (visited != ((32'd1 << n) - 32'd1))
                    return ST_MULTI_COMP;
            end
            count = 4'(n);
            return ST_OK;
        endfunction

        // Store an accepted row; the row that fills the address yields a verdict
        function void note_row(input logic [31:0] ty, input logic [31:0] ed);
            verdict_t v;
            row_edges[row_counter]  = ed;
            row_is_nat[row_counter] = (ty == nat_type);
            row_counter++;
            if (row_counter == NODES)
            begin
                row_counter = 0;
                v.status    = judge(v.node_count);
                awaited.push_back(v);
            end
        endfunction

        function void check_result(input logic [2:0] st, input logic [3:0] cnt);
            verdict_t v;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: status %0d node_count %0d", st, cnt);
                errors++;
            end
            else
            begin
                v = awaited.pop_front();
                if (st !== v.status)
                begin
                    $error("status: expected %0d, got %0d", v.status, st);
                    errors++;
                end
                if (cnt !== v.node_count)
                begin
                    $error("node_count: expected %0d, got %0d", v.node_count, cnt);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] row_type;
    logic [31:0] edge_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        done;
    logic [2:0]  status;
    logic [3:0]  node_count;

    logic [31:0] plan_type [NODES];
    logic [31:0] plan_edges [NODES];
    int          cycle_count = 0;

    address_verdicts verdicts = new();

    dag_address_validator_core #(
        .NODES(NODES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .row_type  (row_type),
        .edge_word (edge_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .status    (status),
        .node_count(node_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Track accepted requests, register writes and results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                verdicts.set_nat(cfg_data);
            if (start && !busy)
                verdicts.note_row(row_type, edge_word);
            if (done)
                verdicts.check_result(status, node_count);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic logic [31:0] other_type(input logic [31:0] nat);
        logic [31:0] v;
        v = $urandom;
        while (v == nat)
            v = $urandom;
        return v;
    endfunction

    // Build one address: well-formed graphs, some with one flaw, some noise
    function automatic void plan_address(input logic [31:0] nat, input int want_n);
        int         n;
        int         i;
        int         k;
        int         cnt;
        int         pos;
        int         r;
        int         p;
        int         kind;
        status_t    flaw;
        logic [7:0] b [4];
        kind = $urandom_range(0, 99);
        if (want_n < 0 && kind < 12)
        begin
            for (i = 0; i < NODES; i++)
            begin
                plan_type[i]  = ($urandom_range(0, 3) == 0) ? nat : $urandom;
                plan_edges[i] = $urandom;
            end
            return;
        end
        if (want_n >= 0)
            n = want_n;
        else if ($urandom_range(0, 1) == 1)
            n = NODES;
        else
            n = $urandom_range(0, NODES);
        for (i = 0; i < NODES; i++)
        begin
            plan_type[i]  = (i < n) ? other_type(nat) : nat;
            plan_edges[i] = $urandom;
            if (i < n)
            begin
                // Point forward, always hitting the next row; the last row closes on row 0
                cnt = $urandom_range(1, 4);
                for (k = 0; k < 4; k++)
                begin
                    if (k >= cnt)
                        b[k] = EMPTY_BYTE;
                    else if (i + 1 < n)
                        b[k] = 8'($urandom_range(i + 1, n - 1));
                    else
                        b[k] = 8'($urandom_range(0, n - 1));
                end
                pos    = $urandom_range(0, cnt - 1);
                b[pos] = (i + 1 < n) ? 8'(i + 1) : 8'd0;
                plan_edges[i] = {b[0], b[1], b[2], b[3]};
            end
        end
        if (want_n >= 0 || kind >= 55)
            return;
        flaw = status_t'($urandom_range(1, 7));
        r    = (n > 0) ? $urandom_range(0, n - 1) : 0;
        case (flaw)
            ST_NAT_MISPLACED:
            begin
                p = $urandom_range(0, NODES - 2);
                plan_type[p]         = nat;
                plan_type[NODES - 1] = other_type(nat);
            end
            ST_CHOSEN:
                if (n > 0)
                    plan_edges[r][8 * $urandom_range(0, 3) + 7] = 1'b1;
            ST_EMPTY_MISPLACED:
                if (n > 0)
                begin
                    p = $urandom_range(0, 2);
                    plan_edges[r][31 - 8 * p -: 8] = EMPTY_BYTE;
                    plan_edges[r][23 - 8 * p -: 8] = 8'($urandom_range(0, 126));
                end
            ST_RANGE:
                if (n > 0)
                    plan_edges[r][31:24] = 8'($urandom_range(n, 126));
            ST_NOT_TOPO:
                if (n >= 2)
                begin
                    p = $urandom_range(0, n - 2);
                    plan_edges[p][31:24] = 8'($urandom_range(0, p));
                end
            ST_NO_ENTRY:
                if (n > 0)
                    plan_edges[n - 1] = EMPTY_ALL;
            ST_MULTI_COMP:
                if (n >= 2)
                    plan_edges[n - 1] = {8'(n - 1), EMPTY_BYTE, EMPTY_BYTE, EMPTY_BYTE};
            default: ;
        endcase
    endfunction

    // Offer one row request; idle first at the given rate, hold until accepted
    task automatic send_row(input logic [31:0] ty, input logic [31:0] ed, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start     = 1'b1;
        row_type  = ty;
        edge_word = ed;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic send_plan(input int idle_pct);
        int i;
        for (i = 0; i < NODES; i++)
            send_row(plan_type[i], plan_edges[i], idle_pct);
    endtask

    // Drop start and wait until every verdict is in and the checker is quiet
    task automatic settle();
        start = 1'b0;
        while (verdicts.awaited.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_nat(input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        int          ph;
        int          a;
        int          i;
        int          idle_pct;
        logic [31:0] nat;
        rst_n     = 1'b0;
        start     = 1'b0;
        row_type  = '0;
        edge_word = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Every row NAT: no node rows, extreme edge words
        write_nat(32'h0);
        for (i = 0; i < NODES; i++)
            send_row(32'h0, (i % 2 == 0) ? ALL_ONES : 32'h0, 0);
        settle();

        // Change the NAT type halfway through an address: four node rows survive
        write_nat(ALL_ONES);
        send_row(32'h0, 32'h017f_7f7f, 0);
        send_row(32'h0, 32'h027f_7f7f, 0);
        send_row(32'h0, 32'h037f_7f7f, 0);
        send_row(32'h0, 32'h007f_7f7f, 0);
        settle();
        write_nat(32'h0);
        for (i = 4; i < NODES; i++)
            send_row(32'h0, $urandom, 0);
        settle();

        // Full nine-node graph with all-ones type words
        plan_address(32'h0, NODES);
        for (i = 0; i < NODES; i++)
            plan_type[i] = ALL_ONES;
        send_plan(0);
        settle();

        // Random addresses across NAT settings and sender idle rates
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                1:       idle_pct = 86;
                3:       idle_pct = 35;
                default: idle_pct = 0;
            endcase
            case (ph)
                0:       nat = ALL_ONES;
                2:       nat = 32'h0;
                5:       nat = ALL_ONES;
                6:       nat = 32'h0;
                default: nat = $urandom;
            endcase
            write_nat(nat);
            for (a = 0; a < ADDRS_PER_RUN; a++)
            begin
                plan_address(nat, -1);
                send_plan(idle_pct);
            end
            settle();
        end

        if (verdicts.errors == 0 && verdicts.awaited.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/dav_pkg.sv
design/dav_lane.sv
design/dav_merge.sv
design/dav_address_validator_top.sv
sim/tb.sv
